// File: rtl/bmpq_pkg.sv
`default_nettype none
package bmpq_pkg;

	localparam int NUM_BINS   = 4096;
	localparam int POOL_NODES = 4096;
	localparam int COORD_BITS = 16;

	localparam int BIN_BITS   = $clog2(NUM_BINS);
	localparam int NODE_BITS  = $clog2(POOL_NODES);
	localparam int INIT_DEPTH = (NUM_BINS > POOL_NODES) ? NUM_BINS : POOL_NODES;
	localparam int INIT_BITS  = $clog2(INIT_DEPTH);

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_REPUSH = 2'd1,
		OP_POP    = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic [BIN_BITS-1:0]   pri;
	} item_t;

	typedef struct packed {
		op_t                   op;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic [BIN_BITS-1:0]   w;
		logic [BIN_BITS-1:0]   wo;
	} req_t;

	// Priorities above the top bin land in the top bin.
	function automatic logic [BIN_BITS-1:0] clamp_bin(input logic [11:0] p);
		if ({5'd0, p} > 17'(NUM_BINS - 1))
			return BIN_BITS'(NUM_BINS - 1);
		return BIN_BITS'(p);
	endfunction

endpackage
`default_nettype wire

// File: rtl/bucket_max_priority_queue_core.sv
`default_nettype none
// Bucket max priority queue for voxel items. Each item (x, y, z, priority) sits in a
// LIFO linked bin of its priority, with nodes drawn from a fixed pool whose free list
// starts at node 0. A front stage classifies each transaction and parks it in a
// two-entry queue; the back stage runs one operation at a time against three
// memories (bin heads, node links, node items), each with one registered read and
// one write per cycle, and leaves the result in an output register, so the next
// transaction can be taken in the same cycle as the waiting result is taken.
// A push takes a node off the free list and links it at the head of its bin; a
// repush walks its old bin up to the item, or to the end of the bin on a miss; a pop
// steps over empty bins to find the current top and, when the popped bin runs empty
// above bin 0, looks at each bin on the way down to the new top. A pool-full,
// empty-pop or unused request is answered straight from the idle state. Every list
// or bin step waits on a registered memory read. After reset a clearing pass walks
// all 4096 bin heads and pool links, clearing the heads and chaining the free list;
// the front queue may take up to two transactions during it, which then wait until
// the pass is over.
module bucket_max_priority_queue_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] item_x,
	input  wire logic [15:0] item_y,
	input  wire logic [15:0] item_z,
	input  wire logic [11:0] priority_req,
	input  wire logic [11:0] old_priority,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [15:0]      out_x,
	output logic [15:0]      out_y,
	output logic [15:0]      out_z,
	output logic [11:0]      out_priority,
	output logic             now_empty,
	output logic [11:0]      item_total
);
	import bmpq_pkg::*;

	req_t                 q_head;
	logic                 q_valid;
	logic                 q_pop;
	status_t              res_status;
	item_t                res_item;
	logic [NODE_BITS-1:0] res_count;

	bmpq_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .item_x, .item_y, .item_z,
		.priority_req, .old_priority, .q_valid, .q_head, .q_pop
	);

	bmpq_back u_back (
		.clk, .arst_n, .q_valid, .q_head, .q_pop, .out_valid, .out_stall,
		.res_status, .res_item, .res_count
	);

	// The count only moves once the waiting result has been taken, so it can be
	// shown straight from the back stage's register.
	assign status       = res_status;
	assign out_x        = 16'(res_item.x);
	assign out_y        = 16'(res_item.y);
	assign out_z        = 16'(res_item.z);
	assign out_priority = 12'(res_item.pri);
	assign now_empty    = (res_count == '0);
	assign item_total   = 12'(res_count);

endmodule
`default_nettype wire

// File: rtl/bmpq_front.sv
`default_nettype none
module bmpq_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        kind,
	input  wire logic [15:0]       item_x,
	input  wire logic [15:0]       item_y,
	input  wire logic [15:0]       item_z,
	input  wire logic [11:0]       priority_req,
	input  wire logic [11:0]       old_priority,
	output logic                   q_valid,
	output bmpq_pkg::req_t         q_head,
	input  wire logic              q_pop
);
	import bmpq_pkg::*;

	req_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	req_t       req;
	logic       push;

	always_comb begin
		// Every two-bit kind has an operation code, the last one being the unused one.
		req.op = op_t'(kind);
		req.x  = item_x[COORD_BITS-1:0];
		req.y  = item_y[COORD_BITS-1:0];
		req.z  = item_z[COORD_BITS-1:0];
		req.w  = clamp_bin(priority_req);
		req.wo = clamp_bin(old_priority);
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_head   = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (q_pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule
`default_nettype wire

// File: rtl/bmpq_back.sv
`default_nettype none
module bmpq_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      q_valid,
	input  wire bmpq_pkg::req_t            q_head,
	output logic                           q_pop,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output bmpq_pkg::status_t              res_status,
	output bmpq_pkg::item_t                res_item,
	output logic [bmpq_pkg::NODE_BITS-1:0] res_count
);
	import bmpq_pkg::*;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_P1, S_P2, S_R1, S_R2, S_R3, S_LK,
		S_Q1, S_Q2, S_Q3, S_Q4, S_Q5
	} state_t;

	logic [NODE_BITS-1:0] bh_mem [NUM_BINS];
	logic [NODE_BITS-1:0] ln_mem [POOL_NODES];
	item_t                it_mem [POOL_NODES];

	state_t               state_q;
	logic [INIT_BITS-1:0] init_q;
	req_t                 req_q;
	logic [BIN_BITS-1:0]  top_q;
	logic [BIN_BITS-1:0]  hr_q;
	logic [NODE_BITS-1:0] cnt_q;
	logic [NODE_BITS-1:0] cur_q;
	logic [NODE_BITS-1:0] prev_q;
	logic [NODE_BITS-1:0] t_q;
	status_t              stat_q;
	item_t                got_q;
	logic                 ov_q;

	logic [NODE_BITS-1:0] bh_rd_q, ln_rd_q;
	item_t                it_rd_q;
	logic [BIN_BITS-1:0]  bh_ra, bh_wa;
	logic [NODE_BITS-1:0] ln_ra, ln_wa, it_ra, it_wa, bh_wd, ln_wd;
	item_t                it_wd;
	logic                 bh_we, ln_we, it_we;
	logic                 start, match;

	assign start = (state_q == S_IDLE) && q_valid && (!ov_q || !out_stall);
	assign q_pop = start;
	assign match = (it_rd_q.x == req_q.x) && (it_rd_q.y == req_q.y) &&
		(it_rd_q.z == req_q.z);

	always_comb begin
		bh_ra = hr_q - BIN_BITS'(1);
		ln_ra = '0;
		it_ra = '0;
		bh_we = 1'b0;
		bh_wa = '0;
		bh_wd = '0;
		ln_we = 1'b0;
		ln_wa = '0;
		ln_wd = '0;
		it_we = 1'b0;
		it_wa = t_q;
		it_wd = '{x: req_q.x, y: req_q.y, z: req_q.z, pri: req_q.w};
		unique case (state_q)
			S_INIT: begin
				bh_we = ({1'b0, init_q} < (INIT_BITS+1)'(NUM_BINS));
				bh_wa = BIN_BITS'(init_q);
				ln_we = ({1'b0, init_q} < (INIT_BITS+1)'(POOL_NODES));
				ln_wa = NODE_BITS'(init_q);
				ln_wd = ({1'b0, init_q} == (INIT_BITS+1)'(POOL_NODES - 1)) ? '0 :
					NODE_BITS'(init_q) + NODE_BITS'(1);
			end
			S_IDLE: begin
				// Pop starts at the top bin, repush walks the old bin.
				unique case (q_head.op)
					OP_POP:    bh_ra = top_q;
					OP_REPUSH: bh_ra = q_head.wo;
					default:   bh_ra = q_head.w;
				endcase
			end
			S_P1: begin
				bh_ra = req_q.w;
				ln_ra = ln_rd_q;
			end
			S_P2: begin
				bh_ra = req_q.w;
				ln_we = 1'b1;
				ln_wd = ln_rd_q;
				it_we = 1'b1;
			end
			S_R1: begin
				it_ra = bh_rd_q;
				ln_ra = bh_rd_q;
			end
			S_R2: begin
				it_ra = ln_rd_q;
				ln_ra = ln_rd_q;
				if (match) begin
					if (prev_q != '0) begin
						ln_we = 1'b1;
						ln_wa = prev_q;
						ln_wd = ln_rd_q;
					end else begin
						bh_we = 1'b1;
						bh_wa = req_q.wo;
						bh_wd = ln_rd_q;
					end
					it_we = 1'b1;
					it_wa = cur_q;
				end
			end
			S_R3: bh_ra = req_q.w;
			S_LK: begin
				ln_we = 1'b1;
				ln_wa = t_q;
				ln_wd = bh_rd_q;
				bh_we = 1'b1;
				bh_wa = req_q.w;
				bh_wd = t_q;
			end
			S_Q1: begin
				it_ra = bh_rd_q;
				ln_ra = bh_rd_q;
			end
			S_Q2: begin
				bh_we = 1'b1;
				bh_wa = hr_q;
				bh_wd = ln_rd_q;
			end
			S_Q3: ;
			S_Q4: begin
				ln_we = 1'b1;
				ln_wa = t_q;
				ln_wd = ln_rd_q;
			end
			S_Q5: begin
				ln_we = 1'b1;
				ln_wd = t_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (bh_we)
			bh_mem[bh_wa] <= bh_wd;
		bh_rd_q <= bh_mem[bh_ra];
	end

	always_ff @(posedge clk) begin
		if (ln_we)
			ln_mem[ln_wa] <= ln_wd;
		ln_rd_q <= ln_mem[ln_ra];
	end

	always_ff @(posedge clk) begin
		if (it_we)
			it_mem[it_wa] <= it_wd;
		it_rd_q <= it_mem[it_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			top_q   <= '0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			stat_q  <= ST_OK;
		end else begin
			if (ov_q && !out_stall)
				ov_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + INIT_BITS'(1);
					if ({1'b0, init_q} == (INIT_BITS+1)'(INIT_DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: if (start) begin
					req_q <= q_head;
					got_q <= '0;
					hr_q  <= top_q;
					prev_q <= '0;
					unique case (q_head.op)
						OP_PUSH: begin
							if (cnt_q == NODE_BITS'(POOL_NODES - 1)) begin
								stat_q <= ST_FULL;
								ov_q   <= 1'b1;
							end else
								state_q <= S_P1;
						end
						OP_REPUSH: state_q <= S_R1;
						OP_POP: begin
							if (cnt_q == '0) begin
								stat_q <= ST_EMPTY;
								ov_q   <= 1'b1;
							end else
								state_q <= S_Q1;
						end
						default: begin
							stat_q <= ST_OK;
							ov_q   <= 1'b1;
						end
					endcase
				end
				S_P1: begin
					t_q     <= ln_rd_q;
					state_q <= S_P2;
				end
				S_P2: state_q <= S_LK;
				S_R1: begin
					cur_q <= bh_rd_q;
					if (bh_rd_q == '0) begin
						stat_q  <= ST_NOT_FOUND;
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end else
						state_q <= S_R2;
				end
				S_R2: begin
					if (match) begin
						t_q     <= cur_q;
						state_q <= S_R3;
					end else begin
						prev_q <= cur_q;
						cur_q  <= ln_rd_q;
						if (ln_rd_q == '0) begin
							stat_q  <= ST_NOT_FOUND;
							ov_q    <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_R3: state_q <= S_LK;
				S_LK: begin
					if (req_q.w > top_q)
						top_q <= req_q.w;
					if (req_q.op == OP_PUSH)
						cnt_q <= cnt_q + NODE_BITS'(1);
					stat_q  <= ST_OK;
					ov_q    <= 1'b1;
					state_q <= S_IDLE;
				end
				S_Q1: begin
					if (bh_rd_q == '0 && hr_q != '0)
						hr_q <= hr_q - BIN_BITS'(1);
					else begin
						t_q     <= bh_rd_q;
						state_q <= S_Q2;
					end
				end
				S_Q2: begin
					got_q <= it_rd_q;
					if (ln_rd_q != '0 || hr_q == '0) begin
						top_q   <= hr_q;
						state_q <= S_Q4;
					end else begin
						hr_q    <= hr_q - BIN_BITS'(1);
						state_q <= S_Q3;
					end
				end
				S_Q3: begin
					if (bh_rd_q != '0 || hr_q == '0) begin
						top_q   <= hr_q;
						state_q <= S_Q4;
					end else
						hr_q <= hr_q - BIN_BITS'(1);
				end
				S_Q4: begin
					cnt_q   <= cnt_q - NODE_BITS'(1);
					state_q <= S_Q5;
				end
				S_Q5: begin
					stat_q  <= ST_OK;
					ov_q    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = ov_q;
	assign res_status = stat_q;
	assign res_item   = got_q;
	assign res_count  = cnt_q;

endmodule
`default_nettype wire

// File: rtl/bmpq_checker.sv
`default_nettype none
module bmpq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic [15:0] out_x,
	input wire logic [11:0] out_priority,
	input wire logic        now_empty,
	input wire logic [11:0] item_total
);
	import bmpq_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(item_total))
		else $error("result changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> now_empty == (item_total == 12'd0))
		else $error("empty flag disagrees with count");

	a_pop_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> out_priority == 12'd0 && out_x == 16'd0 &&
			now_empty)
		else $error("empty pop returned an item");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> item_total == 12'(POOL_NODES - 1))
		else $error("pool full flagged below capacity");

endmodule

bind bucket_max_priority_queue_core bmpq_checker u_checker (
	.clk, .arst_n, .out_valid, .out_stall, .status, .out_x, .out_priority,
	.now_empty, .item_total
);
`default_nettype wire
